>>> rtl/sftr_pkg.sv
// ----------------------------------------------------------------------------
// Sparse triplet fast transpose: shared package
// Field widths, register indexes, command codes, parameter defaults and the
// packed form of one stored triple.
// ----------------------------------------------------------------------------
package sftr_pkg;

  localparam int unsigned MAX_NONZERO_DEF = 64;
  localparam int unsigned MAX_DIM_DEF     = 256;

  localparam int unsigned ROW_W     = 9;
  localparam int unsigned COL_W     = 9;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } triple_t;

endpackage

>>> rtl/sftr_ram.sv
// ----------------------------------------------------------------------------
// Sparse triplet fast transpose: generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sftr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sparse_triplet_fast_transpose_core.sv
// ----------------------------------------------------------------------------
// Sparse triplet fast transpose core
// Collects nonzero triples and emits them transposed, ordered by source
// column and, within a column, by arrival order.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one command per transfer. A stored load
// reads its column count and writes it back, stalling the input in between;
// a dropped load does not stall it. A load whose column is zero, above the
// column count or above MAX_DIM, or which finds the store full, is dropped
// and flagged. A finish runs three passes: a prefix sum over columns 1 up
// to the highest column loaded and a scatter of every stored triple (bound
// by the position memory read-modify-write), both through one shared adder,
// and the emission, which waits while the receiver stalls.
// A finish with no stored triples gives no result. The output register
// holds a result until it is taken; a stall simply holds the sequencer.
// After reset the column count memory is cleared, one entry a cycle, over
// all min(MAX_DIM, 511) entries, during which no input is taken.
// ----------------------------------------------------------------------------
module sparse_triplet_fast_transpose_core #(
  parameter int unsigned MAX_NONZERO = sftr_pkg::MAX_NONZERO_DEF,
  parameter int unsigned MAX_DIM     = sftr_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sftr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sftr_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [sftr_pkg::ROW_W-1:0]     in_row_i,
  input  logic [sftr_pkg::COL_W-1:0]     in_col_i,
  input  logic signed [sftr_pkg::VAL_W-1:0] in_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sftr_pkg::COL_W-1:0]     out_row_o,
  output logic [sftr_pkg::ROW_W-1:0]     out_col_o,
  output logic signed [sftr_pkg::VAL_W-1:0] out_value_o,
  output logic                           last_o,
  output logic                           dropped_o
);

  localparam int unsigned CDEPTH = (MAX_DIM < 511) ? MAX_DIM : 511;
  localparam int unsigned CA_W   = $clog2(CDEPTH);
  localparam int unsigned NZ_AW  = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_NONZERO + 1);
  localparam int unsigned TR_W   = $bits(sftr_pkg::triple_t);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LD_WR = 4'd2;
  localparam logic [3:0] ST_PF_RD = 4'd3;
  localparam logic [3:0] ST_PF_WR = 4'd4;
  localparam logic [3:0] ST_SC_RT = 4'd5;
  localparam logic [3:0] ST_SC_RP = 4'd6;
  localparam logic [3:0] ST_SC_WR = 4'd7;
  localparam logic [3:0] ST_EM_RD = 4'd8;
  localparam logic [3:0] ST_EM_LD = 4'd9;

  logic [3:0]             state_q, state_d;
  logic [sftr_pkg::CFG_W-1:0] num_cols_q;
  logic [CNT_W-1:0]       entry_count_q, entry_count_d;
  logic                   drop_q, drop_d;
  logic [CA_W-1:0]        max_col_q, max_col_d;
  logic [CA_W-1:0]        col_q, col_d;
  logic [CA_W-1:0]        ld_idx_q, ld_idx_d;
  logic [CNT_W-1:0]       sum_q, sum_d;
  logic [NZ_AW-1:0]       k_q, k_d;

  logic                   in_xfer, out_xfer, is_load, is_finish, drop_load;
  logic [sftr_pkg::COL_W-1:0] in_col_m1, sc_col_m1;
  logic [CA_W-1:0]        in_idx, sc_idx;
  logic [CNT_W-1:0]       cnt_last;
  logic                   k_is_last, em_ok;

  logic [CNT_W-1:0]       add_a, add_b, add_y;

  logic                   cnt_we, cnt_re;
  logic [CA_W-1:0]        cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]       cnt_wdata, cnt_rdata;
  logic                   pos_we, pos_re;
  logic [CA_W-1:0]        pos_waddr;
  logic [CNT_W-1:0]       pos_wdata, pos_rdata;
  logic                   tr_we, tr_re;
  sftr_pkg::triple_t      tr_wdata, tr_rdata;
  logic                   sl_we, sl_re;
  sftr_pkg::triple_t      sl_wdata, sl_rdata;

  logic                   out_valid_q;
  sftr_pkg::triple_t      out_q;
  logic                   last_q, dropped_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign is_load    = in_xfer && (command_i == sftr_pkg::CMD_LOAD);
  assign is_finish  = in_xfer && (command_i == sftr_pkg::CMD_FINISH);

  assign in_col_m1 = in_col_i - sftr_pkg::COL_W'(1);
  assign in_idx    = in_col_m1[CA_W-1:0];
  assign drop_load = (in_col_i == '0) || (in_col_i > num_cols_q) ||
                     ({23'd0, in_col_i} > 32'(MAX_DIM)) ||
                     (entry_count_q >= CNT_W'(MAX_NONZERO));

  assign sc_col_m1 = tr_rdata.col - sftr_pkg::COL_W'(1);
  assign sc_idx    = sc_col_m1[CA_W-1:0];
  assign cnt_last  = entry_count_q - CNT_W'(1);
  assign k_is_last = (CNT_W'(k_q) == cnt_last);
  assign em_ok     = !out_valid_q || !out_stall_i;

  // The one adder shared by the count update, the prefix sum and the scatter.
  always_comb begin
    add_a = pos_rdata;
    add_b = CNT_W'(1);
    case (state_q)
      ST_LD_WR: begin
        add_a = cnt_rdata;
        add_b = CNT_W'(1);
      end
      ST_PF_WR: begin
        add_a = sum_q;
        add_b = cnt_rdata;
      end
      default: begin
        add_a = pos_rdata;
        add_b = CNT_W'(1);
      end
    endcase
  end
  assign add_y = add_a + add_b;

  always_comb begin
    state_d       = state_q;
    entry_count_d = entry_count_q;
    drop_d        = drop_q;
    max_col_d     = max_col_q;
    col_d         = col_q;
    ld_idx_d      = ld_idx_q;
    sum_d         = sum_q;
    k_d           = k_q;
    cnt_we        = 1'b0;
    cnt_waddr     = col_q;
    cnt_wdata     = '0;
    cnt_re        = 1'b0;
    cnt_raddr     = col_q;
    pos_we        = 1'b0;
    pos_waddr     = col_q;
    pos_wdata     = sum_q;
    pos_re        = 1'b0;
    tr_we         = 1'b0;
    tr_re         = 1'b0;
    tr_wdata      = '{row: in_row_i, col: in_col_i, value: in_value_i};
    sl_we         = 1'b0;
    sl_re         = 1'b0;
    sl_wdata      = '{row: tr_rdata.col, col: tr_rdata.row, value: tr_rdata.value};
    case (state_q)
      ST_CLEAR: begin
        cnt_we = 1'b1;
        col_d  = col_q + CA_W'(1);
        if (col_q == CA_W'(CDEPTH - 1)) begin
          col_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (is_load) begin
          if (drop_load) begin
            drop_d = 1'b1;
          end else begin
            tr_we         = 1'b1;
            cnt_re        = 1'b1;
            cnt_raddr     = in_idx;
            ld_idx_d      = in_idx;
            entry_count_d = entry_count_q + CNT_W'(1);
            if (in_idx > max_col_q) begin
              max_col_d = in_idx;
            end
            state_d = ST_LD_WR;
          end
        end else if (is_finish) begin
          if (entry_count_q == '0) begin
            drop_d    = 1'b0;
            max_col_d = '0;
          end else begin
            col_d   = '0;
            sum_d   = '0;
            state_d = ST_PF_RD;
          end
        end
      end
      ST_LD_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = ld_idx_q;
        cnt_wdata = add_y;
        state_d   = ST_IDLE;
      end
      ST_PF_RD: begin
        cnt_re  = 1'b1;
        state_d = ST_PF_WR;
      end
      ST_PF_WR: begin
        pos_we = 1'b1;
        cnt_we = 1'b1;
        sum_d  = add_y;
        if (col_q == max_col_q) begin
          k_d     = '0;
          state_d = ST_SC_RT;
        end else begin
          col_d   = col_q + CA_W'(1);
          state_d = ST_PF_RD;
        end
      end
      ST_SC_RT: begin
        tr_re   = 1'b1;
        state_d = ST_SC_RP;
      end
      ST_SC_RP: begin
        pos_re  = 1'b1;
        state_d = ST_SC_WR;
      end
      ST_SC_WR: begin
        sl_we     = 1'b1;
        pos_we    = 1'b1;
        pos_waddr = sc_idx;
        pos_wdata = add_y;
        if (k_is_last) begin
          k_d     = '0;
          state_d = ST_EM_RD;
        end else begin
          k_d     = k_q + NZ_AW'(1);
          state_d = ST_SC_RT;
        end
      end
      ST_EM_RD: begin
        if (em_ok) begin
          sl_re   = 1'b1;
          state_d = ST_EM_LD;
        end
      end
      ST_EM_LD: begin
        if (k_is_last) begin
          entry_count_d = '0;
          drop_d        = 1'b0;
          max_col_d     = '0;
          state_d       = ST_IDLE;
        end else begin
          k_d     = k_q + NZ_AW'(1);
          state_d = ST_EM_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      num_cols_q    <= sftr_pkg::CFG_W'(1);
      entry_count_q <= '0;
      drop_q        <= 1'b0;
      max_col_q     <= '0;
      col_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      drop_q        <= drop_d;
      max_col_q     <= max_col_d;
      col_q         <= col_d;
      // The row count does not affect any result and is not kept.
      if (cfg_we_i && (cfg_index_i == sftr_pkg::CFG_NUM_COLS)) begin
        num_cols_q <= cfg_wdata_i;
      end
      if (state_q == ST_EM_LD) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ld_idx_q <= ld_idx_d;
    sum_q    <= sum_d;
    k_q      <= k_d;
    if (state_q == ST_EM_LD) begin
      out_q     <= sl_rdata;
      last_q    <= k_is_last;
      dropped_q <= drop_q;
    end
  end

  sftr_ram #(.WIDTH(CNT_W), .DEPTH(CDEPTH)) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rdata)
  );

  sftr_ram #(.WIDTH(CNT_W), .DEPTH(CDEPTH)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(pos_waddr),
    .wdata_i(pos_wdata),
    .re_i   (pos_re),
    .raddr_i(sc_idx),
    .rdata_o(pos_rdata)
  );

  sftr_ram #(.WIDTH(TR_W), .DEPTH(MAX_NONZERO)) u_triple_ram (
    .clk_i  (clk_i),
    .we_i   (tr_we),
    .waddr_i(entry_count_q[NZ_AW-1:0]),
    .wdata_i(tr_wdata),
    .re_i   (tr_re),
    .raddr_i(k_q),
    .rdata_o(tr_rdata)
  );

  sftr_ram #(.WIDTH(TR_W), .DEPTH(MAX_NONZERO)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (sl_we),
    .waddr_i(pos_rdata[NZ_AW-1:0]),
    .wdata_i(sl_wdata),
    .re_i   (sl_re),
    .raddr_i(k_q),
    .rdata_o(sl_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_q.row;
  assign out_col_o   = out_q.col;
  assign out_value_o = out_q.value;
  assign last_o      = last_q;
  assign dropped_o   = dropped_q;

endmodule
